>>> src/assert_macros.svh
// Assertion macros used by the tempo search back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define MRAT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cond never holds.
`define MRAT_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> src/mrat_pkg.sv
// Shared constants, types and state codes of the tempo search block.
`timescale 1ns / 1ps

package mrat_pkg;

    // Sample store
    localparam int unsigned MAX_SAMPLES = 1 << 20;
    localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES) + 1;
    localparam int unsigned QUAD_DEPTH  = MAX_SAMPLES >> 2;
    localparam int unsigned QUAD_AW     = $clog2(QUAD_DEPTH);
    localparam int unsigned QUAD_W      = 11;
    localparam int unsigned ENV_W       = 8;
    localparam int unsigned BLK_W       = QUAD_AW + 1;
    localparam int unsigned BSUM_W      = 17;

    // Lag search
    localparam int unsigned START_W     = 20;
    localparam int unsigned STOP_W      = 21;
    localparam int unsigned LAG_W       = 22;
    localparam int unsigned MAX_LAG_SPAN = 1 << 17;
    localparam int unsigned SLOTS       = (MAX_LAG_SPAN >> 2) + 2;
    localparam int unsigned SLOT_W      = $clog2(SLOTS);
    localparam int unsigned MIS_W       = 26;
    localparam int unsigned THR_W       = MIS_W + 1;
    localparam int unsigned NUM_W       = 16;
    localparam int unsigned TOT_W       = 42;
    localparam int unsigned SHIFT_W     = 4;
    localparam int unsigned PER_W       = 6;

    localparam logic [SHIFT_W-1:0] COARSE_SHIFT = SHIFT_W'(8);
    localparam logic [SHIFT_W-1:0] FINE_SHIFT   = SHIFT_W'(2);

    // Register reset values
    localparam logic [START_W-1:0] START_RESET = START_W'(66150);
    localparam logic [STOP_W-1:0]  STOP_RESET  = STOP_W'(132300);

    typedef enum logic [0:0] {
        REG_START_LAG = 1'b0,
        REG_STOP_LAG  = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LVL_INIT,
        B_BLD_RUN,
        B_BLD_DRAIN,
        B_LAG_CHK,
        B_LAG_PRV,
        B_MIS_INIT,
        B_MIS_RUN,
        B_MIS_WAIT,
        B_LAG_WR,
        B_MEAN_MUL,
        B_MEAN_DIV,
        B_MEAN_WAIT,
        B_RESULT
    } back_state_t;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] best_lag;
    } res_t;

endpackage

>>> src/mrat_front.sv
// Front end: takes input beats, builds quad envelope sums, queues analysis commands.
`timescale 1ns / 1ps

module mrat_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            mode,
    input  logic signed [15:0]              left_sample,
    input  logic signed [15:0]              right_sample,
    output logic                            cmd_push,
    output logic [mrat_pkg::CNT_W-1:0]      cmd_cnt,
    input  logic                            cmd_full,
    input  logic                            quad_rd_en,
    input  logic [mrat_pkg::QUAD_AW-1:0]    quad_raddr,
    output logic [mrat_pkg::QUAD_W-1:0]     quad_rdata
);

    logic [mrat_pkg::CNT_W-1:0]  cnt_reg;
    logic [mrat_pkg::QUAD_W-1:0] part_reg;
    logic [mrat_pkg::QUAD_W-1:0] quad_mem [mrat_pkg::QUAD_DEPTH];
    logic [mrat_pkg::QUAD_W-1:0] quad_rdata_reg;

    logic        accept;
    logic        load;
    logic [16:0] ext_l;
    logic [16:0] ext_r;
    logic [16:0] mag_l;
    logic [16:0] mag_r;
    logic [16:0] mag_sum;
    logic [mrat_pkg::QUAD_W-1:0] part_next;

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign load     = accept && !mode && (cnt_reg < mrat_pkg::CNT_W'(mrat_pkg::MAX_SAMPLES));
    assign cmd_push = accept && mode;
    assign cmd_cnt  = cnt_reg;

    // Envelope value of one stereo sample
    always_comb
    begin
        ext_l     = {left_sample[15], left_sample};
        ext_r     = {right_sample[15], right_sample};
        mag_l     = ext_l[16] ? 17'd0 - ext_l : ext_l;
        mag_r     = ext_r[16] ? 17'd0 - ext_r : ext_r;
        mag_sum   = mag_l + mag_r;
        part_next = part_reg + mrat_pkg::QUAD_W'(mag_sum[16:8]);
    end

    // Count samples and fold four envelope values into one quad sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            part_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg[1:0] == 2'b11)
            begin
                part_reg <= '0;
            end
            else
            begin
                part_reg <= part_next;
            end
        end
    end

    // Quad sum store
    always_ff @(posedge clk)
    begin
        if (load && cnt_reg[1:0] == 2'b11)
        begin
            quad_mem[cnt_reg[mrat_pkg::QUAD_AW+1:2]] <= part_next;
        end
        if (quad_rd_en)
        begin
            quad_rdata_reg <= quad_mem[quad_raddr];
        end
    end

    assign quad_rdata = quad_rdata_reg;

endmodule

>>> src/mrat_cmd_fifo.sv
// Two-entry queue of analysis commands between front and back.
`timescale 1ns / 1ps

module mrat_cmd_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [mrat_pkg::CNT_W-1:0]  wr_data,
    output logic                        full,
    input  logic                        rd_en,
    output logic [mrat_pkg::CNT_W-1:0]  rd_data,
    output logic                        empty
);

    logic [mrat_pkg::CNT_W-1:0] entry_reg [2];
    logic                       wr_ptr_reg;
    logic                       rd_ptr_reg;
    logic [1:0]                 fill_reg;
    logic                       do_wr;
    logic                       do_rd;

    assign full    = fill_reg == 2'd2;
    assign empty   = fill_reg == 2'd0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> src/mrat_div.sv
// Restoring divider, one quotient bit per cycle, for the per-level mean.
`timescale 1ns / 1ps

module mrat_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mrat_pkg::TOT_W-1:0]  dividend,
    input  logic [mrat_pkg::NUM_W-1:0]  divisor,
    output logic                        done,
    output logic [mrat_pkg::TOT_W-1:0]  quot
);

    localparam int unsigned STEP_W = $clog2(mrat_pkg::TOT_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [mrat_pkg::NUM_W-1:0]  rem_reg;
    logic [mrat_pkg::NUM_W-1:0]  dsr_reg;
    logic [mrat_pkg::TOT_W-1:0]  quo_reg;
    logic [mrat_pkg::NUM_W:0]    shifted;
    logic [mrat_pkg::NUM_W:0]    diff;
    logic                        ge;

    assign shifted = {rem_reg, quo_reg[mrat_pkg::TOT_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = shifted >= {1'b0, dsr_reg};
    assign done    = done_reg;
    assign quot    = quo_reg;

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(mrat_pkg::TOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift and subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[mrat_pkg::NUM_W-1:0] : shifted[mrat_pkg::NUM_W-1:0];
            quo_reg <= {quo_reg[mrat_pkg::TOT_W-2:0], ge};
        end
    end

endmodule

>>> src/mrat_back.sv
// Back end: per-level envelope build, pruned lag scan, minimum and mean.
`timescale 1ns / 1ps

module mrat_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [mrat_pkg::START_W-1:0]   start_lag,
    input  logic [mrat_pkg::STOP_W-1:0]    stop_lag,
    input  logic                           cmd_empty,
    input  logic [mrat_pkg::CNT_W-1:0]     cmd_cnt,
    output logic                           cmd_pop,
    output logic                           quad_rd_en,
    output logic [mrat_pkg::QUAD_AW-1:0]   quad_raddr,
    input  logic [mrat_pkg::QUAD_W-1:0]    quad_rdata,
    input  logic                           res_ready,
    output logic                           res_push,
    output mrat_pkg::res_t                 res
);

    `include "assert_macros.svh"

    localparam int unsigned ENV_DEPTH = mrat_pkg::QUAD_DEPTH;

    mrat_pkg::back_state_t state_reg;
    mrat_pkg::back_state_t state_next;

    // Analysis and level registers
    logic [mrat_pkg::CNT_W-1:0]    cnt_reg;
    logic [mrat_pkg::LAG_W-1:0]    stop_eff_reg;
    logic [mrat_pkg::SHIFT_W-1:0]  s_reg;
    logic                          sel_reg;
    logic [mrat_pkg::BLK_W-1:0]    blocks_reg;
    logic [mrat_pkg::BLK_W-1:0]    qtot_reg;

    // Envelope build
    logic [mrat_pkg::BLK_W-1:0]    q_reg;
    logic [mrat_pkg::QUAD_AW-1:0]  b_reg;
    logic                          p1_reg;
    logic                          p1_last_reg;
    logic [mrat_pkg::BSUM_W-1:0]   bsum_reg;

    // Lag scan
    logic [mrat_pkg::LAG_W-1:0]    lag_reg;
    logic                          brk_reg;
    logic                          found_reg;
    logic [mrat_pkg::MIS_W-1:0]    minv_reg;
    logic [mrat_pkg::LAG_W-1:0]    best_reg;
    logic [mrat_pkg::TOT_W-1:0]    total_reg;
    logic [mrat_pkg::NUM_W-1:0]    num_reg;
    logic [mrat_pkg::THR_W-1:0]    thr_reg;
    logic [mrat_pkg::TOT_W-1:0]    prod_reg;
    logic [mrat_pkg::BLK_W-1:0]    c_reg;
    logic [mrat_pkg::BLK_W-1:0]    phase_reg;
    logic                          m_p1_reg;
    logic [mrat_pkg::MIS_W-1:0]    macc_reg;
    logic [mrat_pkg::MIS_W-1:0]    mis_reg;
    logic                          wr_vld_reg;
    logic [mrat_pkg::MIS_W:0]      pa_reg;
    logic [mrat_pkg::MIS_W:0]      pb_reg;
    logic [mrat_pkg::ENV_W-1:0]    ea_reg;
    logic [mrat_pkg::ENV_W-1:0]    eb_reg;

    // Memories
    logic [mrat_pkg::ENV_W-1:0]    env_mem [ENV_DEPTH];
    logic [mrat_pkg::MIS_W:0]      mis0_mem [mrat_pkg::SLOTS];
    logic [mrat_pkg::MIS_W:0]      mis1_mem [mrat_pkg::SLOTS];

    // Combinational terms
    logic [mrat_pkg::LAG_W-1:0]    step;
    logic [mrat_pkg::LAG_W-1:0]    step2;
    logic [mrat_pkg::LAG_W-1:0]    lim;
    logic [mrat_pkg::LAG_W-1:0]    first_up;
    logic [mrat_pkg::LAG_W-1:0]    first;
    logic [mrat_pkg::BLK_W-1:0]    blocks;
    logic [mrat_pkg::BLK_W-1:0]    qtot;
    logic [mrat_pkg::SHIFT_W-1:0]  per_sh;
    logic [mrat_pkg::PER_W-1:0]    per_mask;
    logic [mrat_pkg::LAG_W-1:0]    phase;
    logic [mrat_pkg::LAG_W-1:0]    pst;
    logic [mrat_pkg::LAG_W-1:0]    nst;
    logic [mrat_pkg::LAG_W-1:0]    next_lag;
    logic [mrat_pkg::SLOT_W-1:0]   slot_pst;
    logic [mrat_pkg::SLOT_W-1:0]   slot_nst;
    logic [mrat_pkg::SLOT_W-1:0]   slot_lag;
    logic                          chk_top;
    logic                          chk_skip;
    logic                          chk_brk;
    logic                          prv_hit;
    logic                          env_rd_en;
    logic                          env_we;
    logic                          prv_rd_en;
    logic                          mem_wr_en;
    logic                          div_start;
    logic                          div_done;
    logic [mrat_pkg::TOT_W-1:0]    div_quot;
    logic [mrat_pkg::TOT_W-1:0]    div_dividend;
    logic [mrat_pkg::NUM_W-1:0]    div_divisor;
    logic [mrat_pkg::BSUM_W-1:0]   bsum_next;
    logic [mrat_pkg::ENV_W-1:0]    ediff;
    logic [mrat_pkg::MIS_W-1:0]    macc_next;
    logic [mrat_pkg::QUAD_AW-1:0]  eb_addr;
    logic                          new_min;
    mrat_pkg::back_state_t         level_end;

    // Level geometry and lag bracketing
    always_comb
    begin
        step      = mrat_pkg::LAG_W'(1) << s_reg;
        step2     = step << 1;
        lim       = mrat_pkg::LAG_W'(start_lag) + mrat_pkg::LAG_W'(mrat_pkg::MAX_LAG_SPAN);
        first_up  = mrat_pkg::LAG_W'(start_lag) + step - mrat_pkg::LAG_W'(1);
        first     = (first_up >> s_reg) << s_reg;
        blocks    = mrat_pkg::BLK_W'(cnt_reg >> s_reg);
        per_sh    = s_reg - mrat_pkg::FINE_SHIFT;
        qtot      = blocks << per_sh;
        per_mask  = mrat_pkg::PER_W'((7'd1 << per_sh) - 7'd1);
        phase     = lag_reg >> s_reg;
        pst       = lag_reg & ~(step2 - mrat_pkg::LAG_W'(1));
        nst       = pst + step2;
        next_lag  = lag_reg + step;
        slot_pst  = mrat_pkg::SLOT_W'((pst >> 2) - mrat_pkg::LAG_W'(start_lag[19:2]));
        slot_nst  = mrat_pkg::SLOT_W'((nst >> 2) - mrat_pkg::LAG_W'(start_lag[19:2]));
        slot_lag  = mrat_pkg::SLOT_W'((lag_reg >> 2) - mrat_pkg::LAG_W'(start_lag[19:2]));
        chk_top   = s_reg == mrat_pkg::COARSE_SHIFT;
        chk_skip  = pst < mrat_pkg::LAG_W'(start_lag);
        chk_brk   = brk_reg || (!chk_skip && nst >= stop_eff_reg);
        prv_hit   = (pa_reg[mrat_pkg::MIS_W] && {1'b0, pa_reg[mrat_pkg::MIS_W-1:0]} < thr_reg)
                 || (pb_reg[mrat_pkg::MIS_W] && {1'b0, pb_reg[mrat_pkg::MIS_W-1:0]} < thr_reg);
        bsum_next = bsum_reg + mrat_pkg::BSUM_W'(quad_rdata);
        ediff     = (ea_reg > eb_reg) ? ea_reg - eb_reg : eb_reg - ea_reg;
        macc_next = m_p1_reg ? macc_reg + mrat_pkg::MIS_W'(ediff) : macc_reg;
        eb_addr   = mrat_pkg::QUAD_AW'(c_reg - phase_reg);
        new_min   = wr_vld_reg && (!found_reg || mis_reg < minv_reg);
        level_end = (s_reg == mrat_pkg::FINE_SHIFT) ? mrat_pkg::B_RESULT : mrat_pkg::B_MEAN_MUL;
        div_dividend = total_reg - prod_reg;
        div_divisor  = (num_reg == '0) ? mrat_pkg::NUM_W'(1) : num_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrat_pkg::B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    state_next = mrat_pkg::B_LVL_INIT;
                end
            end
            mrat_pkg::B_LVL_INIT:
            begin
                state_next = mrat_pkg::B_BLD_RUN;
            end
            mrat_pkg::B_BLD_RUN:
            begin
                if (q_reg + 1'b1 >= qtot_reg)
                begin
                    state_next = mrat_pkg::B_BLD_DRAIN;
                end
            end
            mrat_pkg::B_BLD_DRAIN:
            begin
                state_next = (lag_reg < stop_eff_reg) ? mrat_pkg::B_LAG_CHK : level_end;
            end
            mrat_pkg::B_LAG_CHK:
            begin
                priority if (chk_top)
                begin
                    state_next = mrat_pkg::B_MIS_INIT;
                end
                else if (chk_skip || chk_brk)
                begin
                    state_next = mrat_pkg::B_LAG_WR;
                end
                else
                begin
                    state_next = mrat_pkg::B_LAG_PRV;
                end
            end
            mrat_pkg::B_LAG_PRV:
            begin
                state_next = prv_hit ? mrat_pkg::B_MIS_INIT : mrat_pkg::B_LAG_WR;
            end
            mrat_pkg::B_MIS_INIT:
            begin
                state_next = (phase >= mrat_pkg::LAG_W'(blocks_reg)) ? mrat_pkg::B_LAG_WR
                                                                       : mrat_pkg::B_MIS_RUN;
            end
            mrat_pkg::B_MIS_RUN:
            begin
                if (c_reg + 1'b1 >= blocks_reg)
                begin
                    state_next = mrat_pkg::B_MIS_WAIT;
                end
            end
            mrat_pkg::B_MIS_WAIT:
            begin
                state_next = mrat_pkg::B_LAG_WR;
            end
            mrat_pkg::B_LAG_WR:
            begin
                state_next = (next_lag < stop_eff_reg) ? mrat_pkg::B_LAG_CHK : level_end;
            end
            mrat_pkg::B_MEAN_MUL:
            begin
                state_next = mrat_pkg::B_MEAN_DIV;
            end
            mrat_pkg::B_MEAN_DIV:
            begin
                state_next = mrat_pkg::B_MEAN_WAIT;
            end
            mrat_pkg::B_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    state_next = mrat_pkg::B_LVL_INIT;
                end
            end
            mrat_pkg::B_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = mrat_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = mrat_pkg::B_IDLE;
            end
        endcase
    end

    // Strobes from state
    always_comb
    begin
        cmd_pop    = (state_reg == mrat_pkg::B_IDLE) && !cmd_empty;
        quad_rd_en = (state_reg == mrat_pkg::B_BLD_RUN) && (q_reg < qtot_reg);
        prv_rd_en  = (state_reg == mrat_pkg::B_LAG_CHK) && !chk_top && !chk_skip && !chk_brk;
        env_rd_en  = state_reg == mrat_pkg::B_MIS_RUN;
        mem_wr_en  = state_reg == mrat_pkg::B_LAG_WR;
        div_start  = state_reg == mrat_pkg::B_MEAN_DIV;
        res_push   = (state_reg == mrat_pkg::B_RESULT) && res_ready;
    end

    assign env_we       = p1_reg && p1_last_reg;
    assign quad_raddr   = mrat_pkg::QUAD_AW'(q_reg);
    assign res.found    = found_reg;
    assign res.best_lag = best_reg[mrat_pkg::START_W-1:0];

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrat_pkg::B_IDLE;
            p1_reg    <= 1'b0;
            m_p1_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p1_reg    <= quad_rd_en;
            m_p1_reg  <= env_rd_en;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        p1_last_reg <= (q_reg[mrat_pkg::PER_W-1:0] & per_mask) == per_mask;

        // Fold quads into block sums
        if (p1_reg)
        begin
            if (p1_last_reg)
            begin
                bsum_reg <= '0;
                b_reg    <= b_reg + 1'b1;
            end
            else
            begin
                bsum_reg <= bsum_next;
            end
        end

        macc_reg <= macc_next;

        unique case (state_reg)
            mrat_pkg::B_IDLE:
            begin
                cnt_reg      <= cmd_cnt;
                stop_eff_reg <= (mrat_pkg::LAG_W'(stop_lag) > lim) ? lim
                                                                   : mrat_pkg::LAG_W'(stop_lag);
                s_reg        <= mrat_pkg::COARSE_SHIFT;
                sel_reg      <= 1'b0;
            end
            mrat_pkg::B_LVL_INIT:
            begin
                blocks_reg <= blocks;
                qtot_reg   <= qtot;
                q_reg      <= '0;
                b_reg      <= '0;
                bsum_reg   <= '0;
                lag_reg    <= first;
                brk_reg    <= 1'b0;
                found_reg  <= 1'b0;
                minv_reg   <= '0;
                best_reg   <= '0;
                total_reg  <= '0;
                num_reg    <= '0;
            end
            mrat_pkg::B_BLD_RUN:
            begin
                if (quad_rd_en)
                begin
                    q_reg <= q_reg + 1'b1;
                end
            end
            mrat_pkg::B_LAG_CHK:
            begin
                wr_vld_reg <= 1'b0;
                if (!chk_top && !chk_skip && chk_brk)
                begin
                    brk_reg <= 1'b1;
                end
            end
            mrat_pkg::B_LAG_PRV:
            begin
                wr_vld_reg <= 1'b0;
            end
            mrat_pkg::B_MIS_INIT:
            begin
                phase_reg  <= mrat_pkg::BLK_W'(phase);
                c_reg      <= mrat_pkg::BLK_W'(phase);
                macc_reg   <= '0;
                mis_reg    <= '0;
                wr_vld_reg <= 1'b1;
            end
            mrat_pkg::B_MIS_RUN:
            begin
                c_reg <= c_reg + 1'b1;
            end
            mrat_pkg::B_MIS_WAIT:
            begin
                mis_reg <= macc_next;
            end
            mrat_pkg::B_LAG_WR:
            begin
                lag_reg <= next_lag;
                if (wr_vld_reg)
                begin
                    total_reg <= total_reg + mrat_pkg::TOT_W'(mis_reg);
                    num_reg   <= num_reg + 1'b1;
                end
                if (new_min)
                begin
                    found_reg <= 1'b1;
                    minv_reg  <= mis_reg;
                    best_reg  <= lag_reg;
                end
            end
            mrat_pkg::B_MEAN_MUL:
            begin
                prod_reg <= mrat_pkg::TOT_W'(num_reg * minv_reg);
            end
            mrat_pkg::B_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    thr_reg <= div_quot[mrat_pkg::THR_W-1:0] + mrat_pkg::THR_W'(minv_reg);
                    s_reg   <= s_reg - 1'b1;
                    sel_reg <= !sel_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Envelope store
    always_ff @(posedge clk)
    begin
        if (env_we)
        begin
            env_mem[b_reg] <= mrat_pkg::ENV_W'(bsum_next >> s_reg);
        end
        if (env_rd_en)
        begin
            ea_reg <= env_mem[mrat_pkg::QUAD_AW'(c_reg)];
            eb_reg <= env_mem[eb_addr];
        end
    end

    // Mismatch stores, swapped each level: current is written, previous is read
    always_ff @(posedge clk)
    begin
        if (mem_wr_en && !sel_reg)
        begin
            mis0_mem[slot_lag] <= {wr_vld_reg, mis_reg};
        end
        if (mem_wr_en && sel_reg)
        begin
            mis1_mem[slot_lag] <= {wr_vld_reg, mis_reg};
        end
        if (prv_rd_en)
        begin
            pa_reg <= sel_reg ? mis0_mem[slot_pst] : mis1_mem[slot_pst];
            pb_reg <= sel_reg ? mis0_mem[slot_nst] : mis1_mem[slot_nst];
        end
    end

    mrat_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot)
    );

    `MRAT_ASSERT_IMPL(a_quad_rd_loaded, quad_rd_en, q_reg < cnt_reg[mrat_pkg::CNT_W-1:2], "quad read beyond loaded samples")
    `MRAT_ASSERT_IMPL(a_env_rd_built, env_rd_en, c_reg < blocks_reg && phase_reg <= c_reg, "envelope read outside built blocks")
    `MRAT_ASSERT_IMPL(a_lag_in_range, mem_wr_en, lag_reg < stop_eff_reg && slot_lag < mrat_pkg::SLOT_W'(mrat_pkg::SLOTS), "lag written outside search range")
    `MRAT_ASSERT_NEVER(a_div_overlap, div_start && state_reg == mrat_pkg::B_MEAN_WAIT, "divider restarted while busy")

endmodule

>>> src/multires_amdf_tempo_search.sv
// Top level: config registers, front end, command queue, back end, result register.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------------
//  input    | push / full                  | mode, left_sample, right_sample
//  result   | empty / pop                  | best_lag, found
//  config   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// Sample beats (mode 0) stream at one sample per cycle while full is low.
// A start beat (mode 1) queues an analysis; per level the back end then reads the
// quad sums, scans each examined lag through the two-port envelope memory and,
// on every level but the finest, runs the mean divider.
// Reset clears control state; sample, envelope and mismatch stores need no clearing.
// Input stalls only when two analyses are queued; the result waits in its own register.
`timescale 1ns / 1ps

module multires_amdf_tempo_search (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          mode,
    input  logic signed [15:0]            left_sample,
    input  logic signed [15:0]            right_sample,
    output logic                          empty,
    input  logic                          pop,
    output logic [mrat_pkg::START_W-1:0]  best_lag,
    output logic                          found,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [mrat_pkg::START_W-1:0] start_lag_reg;
    logic [mrat_pkg::STOP_W-1:0]  stop_lag_reg;
    mrat_pkg::reg_idx_t           cfg_idx;
    logic                         cfg_wr;

    logic                         cmd_push;
    logic [mrat_pkg::CNT_W-1:0]   cmd_wdata;
    logic                         cmd_full;
    logic                         cmd_pop;
    logic [mrat_pkg::CNT_W-1:0]   cmd_rdata;
    logic                         cmd_empty;
    logic                         quad_rd_en;
    logic [mrat_pkg::QUAD_AW-1:0] quad_raddr;
    logic [mrat_pkg::QUAD_W-1:0]  quad_rdata;
    logic                         res_push;
    mrat_pkg::res_t               res;
    logic                         res_vld_reg;
    mrat_pkg::res_t               res_reg;

    assign pready  = 1'b1;
    assign cfg_idx = mrat_pkg::reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Config write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_lag_reg <= mrat_pkg::START_RESET;
            stop_lag_reg  <= mrat_pkg::STOP_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                mrat_pkg::REG_START_LAG: start_lag_reg <= pwdata[mrat_pkg::START_W-1:0];
                mrat_pkg::REG_STOP_LAG:  stop_lag_reg  <= pwdata[mrat_pkg::STOP_W-1:0];
                default:                 start_lag_reg <= start_lag_reg;
            endcase
        end
    end

    // Config read
    always_comb
    begin
        unique case (cfg_idx)
            mrat_pkg::REG_START_LAG: prdata = 32'(start_lag_reg);
            mrat_pkg::REG_STOP_LAG:  prdata = 32'(stop_lag_reg);
            default:                 prdata = '0;
        endcase
    end

    mrat_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .cmd_push     (cmd_push),
        .cmd_cnt      (cmd_wdata),
        .cmd_full     (cmd_full),
        .quad_rd_en   (quad_rd_en),
        .quad_raddr   (quad_raddr),
        .quad_rdata   (quad_rdata)
    );

    mrat_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_wdata),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rdata),
        .empty   (cmd_empty)
    );

    mrat_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_lag  (start_lag_reg),
        .stop_lag   (stop_lag_reg),
        .cmd_empty  (cmd_empty),
        .cmd_cnt    (cmd_rdata),
        .cmd_pop    (cmd_pop),
        .quad_rd_en (quad_rd_en),
        .quad_raddr (quad_raddr),
        .quad_rdata (quad_rdata),
        .res_ready  (!res_vld_reg),
        .res_push   (res_push),
        .res        (res)
    );

    // Hold the result beat until popped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (res_push)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (pop)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_reg <= res;
        end
    end

    assign empty    = !res_vld_reg;
    assign best_lag = res_reg.best_lag;
    assign found    = res_reg.found;

endmodule
